@@ rtl/core/kfls_pkg.sv @@
// shared types, constants and codes of the keyframe linear sampler
package kfls_pkg;

   localparam int VAL_W          = 32;
   localparam int NUM_W          = 16;
   localparam int SLOT_W         = 4;
   localparam int CSR_W          = 5;
   localparam int LANES          = 5;
   localparam int KEYFRAMES_DEF  = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FULL_TURN      = 360;
   localparam int QUEUE_DEPTH    = 2;

   // lane order of the five keyframe values
   localparam int LANE_X   = 0;
   localparam int LANE_Y   = 1;
   localparam int LANE_ROT = 2;
   localparam int LANE_SX  = 3;
   localparam int LANE_SY  = 4;

   typedef logic [LANES-1:0][VAL_W-1:0] lanes_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MATCH_EXACT  = 2'd0,
      MATCH_INTERP = 2'd1,
      MATCH_NONE   = 2'd2
   } match_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic [NUM_W-1:0]  frame_number;
      lanes_type         vals;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_head_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      lanes_type        vals;
   } key_entry_type;

endpackage

@@ rtl/core/kfls_req_if.sv @@
// request channel: keyframe writes and sample requests
interface kfls_req_if;
   import kfls_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [SLOT_W-1:0]   slot;
   logic signed [NUM_W-1:0] frame_number;
   logic signed [VAL_W-1:0] trans_x;
   logic signed [VAL_W-1:0] trans_y;
   logic signed [VAL_W-1:0] rotation;
   logic signed [VAL_W-1:0] scale_x;
   logic signed [VAL_W-1:0] scale_y;

   modport source (output valid, kind, slot, frame_number, trans_x, trans_y, rotation,
                   scale_x, scale_y, input ready);
   modport sink   (input valid, kind, slot, frame_number, trans_x, trans_y, rotation,
                   scale_x, scale_y, output ready);
endinterface

@@ rtl/core/kfls_rsp_if.sv @@
// response channel: sampled keyframe values
interface kfls_rsp_if;
   import kfls_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] out_x;
   logic signed [VAL_W-1:0] out_y;
   logic signed [VAL_W-1:0] out_rotation;
   logic signed [VAL_W-1:0] out_scale_x;
   logic signed [VAL_W-1:0] out_scale_y;
   logic [1:0]              match_kind;

   modport source (output valid, out_x, out_y, out_rotation, out_scale_x, out_scale_y,
                   match_kind, input ready);
   modport sink   (input valid, out_x, out_y, out_rotation, out_scale_x, out_scale_y,
                   match_kind, output ready);
endinterface

@@ rtl/core/kfls_front.sv @@
// front end: takes request transfers, classifies them and queues them
module kfls_front #(
   parameter int KEYFRAMES = kfls_pkg::KEYFRAMES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   kfls_req_if.sink            req_chan,
   output kfls_pkg::q_head_type q_head,
   input  logic                q_pop
);
   import kfls_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_item_type       fifo_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             push;
   q_item_type       item;

   // classify: writes outside the table are dropped
   always_comb begin
      item.op           = req_chan.kind ? OP_SAMPLE : OP_WRITE;
      item.slot         = req_chan.slot;
      item.frame_number = req_chan.frame_number;
      item.vals[LANE_X]   = req_chan.trans_x;
      item.vals[LANE_Y]   = req_chan.trans_y;
      item.vals[LANE_ROT] = req_chan.rotation;
      item.vals[LANE_SX]  = req_chan.scale_x;
      item.vals[LANE_SY]  = req_chan.scale_y;
   end

   assign req_chan.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign accept = req_chan.valid && req_chan.ready;
   assign push   = accept && (req_chan.kind || (32'(req_chan.slot) < KEYFRAMES));

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = fifo_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH)
      else $error("queue count overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(QUEUE_DEPTH) |-> !req_chan.ready)
      else $error("request accepted while queue full");
`endif

endmodule

@@ rtl/core/kfls_back.sv @@
// back end: keyframe table, slot scan, interpolation and rotation wrap
module kfls_back #(
   parameter int KEYFRAMES = kfls_pkg::KEYFRAMES_DEF,
   parameter int FRAC_BITS = kfls_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kfls_pkg::q_head_type       q_head,
   output logic                       q_pop,
   input  logic [kfls_pkg::CSR_W-1:0] frames_in_use,
   kfls_rsp_if.source                 rsp_chan
);
   import kfls_pkg::*;

   localparam int IDX_W   = $clog2(KEYFRAMES);
   localparam int CNT_W   = $clog2(KEYFRAMES + 1);
   localparam int DIFF_W  = VAL_W + 1;
   localparam int NUMD_W  = NUM_W + 1;
   localparam int PROD_W  = DIFF_W + NUMD_W + 1;
   localparam int DVD_W   = 49;
   localparam int QUO_W   = DIFF_W;
   localparam int SUM_W   = VAL_W + 2;
   localparam int WRAP_W  = 35;
   localparam int STEP_W  = 6;
   localparam longint TURN_L = longint'(FULL_TURN) << FRAC_BITS;
   localparam longint KT_L   = ((longint'(64'h8000_0000) + TURN_L - 1) / TURN_L) * TURN_L;
   localparam longint QMAX_L = (KT_L + longint'(64'h8000_0000)) / TURN_L;
   localparam int     QBITS  = $clog2(QMAX_L + 1);
   localparam logic [WRAP_W-1:0] TURN = WRAP_W'(TURN_L);
   localparam logic [WRAP_W-1:0] KT   = WRAP_W'(KT_L);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_SCAN = 11'b000_0000_0010,
      S_RDA  = 11'b000_0000_0100,
      S_RDB  = 11'b000_0000_1000,
      S_MUL  = 11'b000_0001_0000,
      S_PREP = 11'b000_0010_0000,
      S_DIV  = 11'b000_0100_0000,
      S_SUM  = 11'b000_1000_0000,
      S_WRAP = 11'b001_0000_0000,
      S_OUT  = 11'b010_0000_0000,
      S_ZERO = 11'b100_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   key_entry_type           mem [KEYFRAMES];
   key_entry_type           rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic signed [NUM_W-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pidx_ff, pidx_in;
   logic                    exact_hit_ff, exact_hit_in;
   logic [IDX_W-1:0]        exact_idx_ff, exact_idx_in;
   logic                    prev_hit_ff, prev_hit_in;
   logic [IDX_W-1:0]        prev_idx_ff, prev_idx_in;
   logic signed [NUM_W-1:0] prev_num_ff, prev_num_in;
   logic                    next_hit_ff, next_hit_in;
   logic [IDX_W-1:0]        next_idx_ff, next_idx_in;
   logic signed [NUM_W-1:0] next_num_ff, next_num_in;
   logic [NUMD_W-1:0]       num_ff, num_in;
   logic [NUMD_W-1:0]       den_ff, den_in;
   lanes_type               a_ff, a_in;
   lanes_type               res_ff, res_in;
   logic signed [DIFF_W-1:0] diff_ff [LANES];
   logic signed [DIFF_W-1:0] diff_in [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [PROD_W-1:0] prod_in [LANES];
   logic [LANES-1:0]        neg_ff, neg_in;
   logic [DVD_W-1:0]        dvd_ff [LANES];
   logic [DVD_W-1:0]        dvd_in [LANES];
   logic [NUMD_W-1:0]       rem_ff [LANES];
   logic [NUMD_W-1:0]       rem_in [LANES];
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [WRAP_W-1:0]       wdvd_ff, wdvd_in;
   match_type               match_ff, match_in;
   logic                    issue;
   logic                    scan_done;
   logic                    mem_we;
   logic signed [NUM_W-1:0] k;

   assign k         = $signed(rd_data_ff.num);
   assign issue     = (state_ff == S_SCAN) && (cnt_ff < n_ff);
   assign scan_done = (state_ff == S_SCAN) && !issue && !pend_ff;
   assign q_pop     = (state_ff == S_IDLE) && q_head.valid;
   assign mem_we    = q_pop && (q_head.item.op == OP_WRITE);

   // read address of the table
   always_comb begin
      rd_addr = cnt_ff[IDX_W-1:0];
      if (state_ff == S_SCAN && !issue) begin
         rd_addr = exact_hit_ff ? exact_idx_ff : prev_idx_ff;
      end else if (state_ff == S_RDA) begin
         rd_addr = next_idx_ff;
      end
   end

   // keyframe table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[IDX_W'(q_head.item.slot)] <= '{num: q_head.item.frame_number,
                                            vals: q_head.item.vals};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer
   always_comb begin
      logic [NUMD_W:0]   rsh;
      logic [WRAP_W-1:0] wsh;
      logic [WRAP_W-1:0] tsh;
      logic [QUO_W-1:0]  q;
      logic signed [SUM_W-1:0] sum;
      logic signed [PROD_W-1:0] mag;

      state_in     = state_ff;
      frame_in     = frame_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pidx_in      = cnt_ff[IDX_W-1:0];
      exact_hit_in = exact_hit_ff;
      exact_idx_in = exact_idx_ff;
      prev_hit_in  = prev_hit_ff;
      prev_idx_in  = prev_idx_ff;
      prev_num_in  = prev_num_ff;
      next_hit_in  = next_hit_ff;
      next_idx_in  = next_idx_ff;
      next_num_in  = next_num_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      a_in         = a_ff;
      res_in       = res_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      wdvd_in      = wdvd_ff;
      match_in     = match_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_head.valid && q_head.item.op == OP_SAMPLE) begin
               frame_in     = $signed(q_head.item.frame_number);
               n_in         = (32'(frames_in_use) > KEYFRAMES) ? CNT_W'(KEYFRAMES)
                                                               : CNT_W'(frames_in_use);
               cnt_in       = '0;
               exact_hit_in = 1'b0;
               prev_hit_in  = 1'b0;
               next_hit_in  = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               cnt_in  = cnt_ff + 1'b1;
               pend_in = 1'b1;
            end
            // compare the slot read last cycle
            if (pend_ff) begin
               if (k == frame_ff) begin
                  exact_hit_in = 1'b1;
                  exact_idx_in = pidx_ff;
               end
               if (k < frame_ff && (!prev_hit_ff || prev_num_ff < k)) begin
                  prev_hit_in = 1'b1;
                  prev_idx_in = pidx_ff;
                  prev_num_in = k;
               end
               if (k > frame_ff && (!next_hit_ff || next_num_ff > k)) begin
                  next_hit_in = 1'b1;
                  next_idx_in = pidx_ff;
                  next_num_in = k;
               end
            end
            if (scan_done) begin
               num_in = NUMD_W'({frame_ff[NUM_W-1], frame_ff}
                                - {prev_num_ff[NUM_W-1], prev_num_ff});
               den_in = NUMD_W'({next_num_ff[NUM_W-1], next_num_ff}
                                - {prev_num_ff[NUM_W-1], prev_num_ff});
               if (exact_hit_ff || (prev_hit_ff && next_hit_ff)) begin
                  state_in = S_RDA;
               end else begin
                  state_in = S_ZERO;
               end
            end
         end
         S_RDA: begin
            if (exact_hit_ff) begin
               res_in   = rd_data_ff.vals;
               match_in = MATCH_EXACT;
               state_in = S_OUT;
            end else begin
               a_in     = rd_data_ff.vals;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            for (int i = 0; i < LANES; i++) begin
               diff_in[i] = DIFF_W'($signed(rd_data_ff.vals[i])) - DIFF_W'($signed(a_ff[i]));
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            for (int i = 0; i < LANES; i++) begin
               prod_in[i] = PROD_W'(diff_ff[i]) * PROD_W'($signed({1'b0, num_ff}));
            end
            state_in = S_PREP;
         end
         S_PREP: begin
            for (int i = 0; i < LANES; i++) begin
               mag        = prod_ff[i][PROD_W-1] ? -prod_ff[i] : prod_ff[i];
               neg_in[i]  = prod_ff[i][PROD_W-1];
               dvd_in[i]  = DVD_W'(mag) + DVD_W'(den_ff >> 1);
               rem_in[i]  = '0;
            end
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle in every lane
            for (int i = 0; i < LANES; i++) begin
               rsh = {rem_ff[i], dvd_ff[i][DVD_W-1]};
               if (rsh >= {1'b0, den_ff}) begin
                  rem_in[i] = NUMD_W'(rsh - {1'b0, den_ff});
                  dvd_in[i] = {dvd_ff[i][DVD_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = NUMD_W'(rsh);
                  dvd_in[i] = {dvd_ff[i][DVD_W-2:0], 1'b0};
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            for (int i = 0; i < LANES; i++) begin
               q   = dvd_ff[i][QUO_W-1:0];
               sum = SUM_W'($signed(a_ff[i])) + (neg_ff[i] ? -SUM_W'({1'b0, q})
                                                            : SUM_W'({1'b0, q}));
               res_in[i] = sum[VAL_W-1:0];
               if (i == LANE_ROT) begin
                  wdvd_in = WRAP_W'(sum) + KT;
               end
            end
            step_in  = STEP_W'(QBITS - 1);
            state_in = S_WRAP;
         end
         S_WRAP: begin
            // subtract shifted full turns, two quotient bits per cycle
            wsh = wdvd_ff;
            for (int j = 0; j < 2; j++) begin
               if (32'(step_ff) >= j) begin
                  tsh = TURN << (32'(step_ff) - j);
                  if (wsh >= tsh) begin
                     wsh = wsh - tsh;
                  end
               end
            end
            wdvd_in = wsh;
            step_in = step_ff - STEP_W'(2);
            if (step_ff < STEP_W'(2)) begin
               res_in[LANE_ROT] = wsh[VAL_W-1:0];
               match_in         = MATCH_INTERP;
               state_in         = S_OUT;
            end
         end
         S_ZERO: begin
            res_in   = '0;
            match_in = MATCH_NONE;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      frame_ff     <= frame_in;
      n_ff         <= n_in;
      cnt_ff       <= cnt_in;
      pidx_ff      <= pidx_in;
      exact_hit_ff <= exact_hit_in;
      exact_idx_ff <= exact_idx_in;
      prev_hit_ff  <= prev_hit_in;
      prev_idx_ff  <= prev_idx_in;
      prev_num_ff  <= prev_num_in;
      next_hit_ff  <= next_hit_in;
      next_idx_ff  <= next_idx_in;
      next_num_ff  <= next_num_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      a_ff         <= a_in;
      res_ff       <= res_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      wdvd_ff      <= wdvd_in;
      match_ff     <= match_in;
   end

   // response register
   assign rsp_chan.valid        = (state_ff == S_OUT);
   assign rsp_chan.out_x        = res_ff[LANE_X];
   assign rsp_chan.out_y        = res_ff[LANE_Y];
   assign rsp_chan.out_rotation = res_ff[LANE_ROT];
   assign rsp_chan.out_scale_x  = res_ff[LANE_SX];
   assign rsp_chan.out_scale_y  = res_ff[LANE_SY];
   assign rsp_chan.match_kind   = match_ff;

`ifndef NO_ASSERTIONS
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> den_ff != '0)
      else $error("interpolation divisor is zero");
   a_rot_wrapped: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && match_ff == MATCH_INTERP) |-> WRAP_W'(res_ff[LANE_ROT]) < TURN
         || TURN > WRAP_W'(64'hFFFF_FFFF))
      else $error("interpolated rotation outside full turn");
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && match_ff == MATCH_NONE) |-> res_ff == '0)
      else $error("unbracketed sample with nonzero values");
   a_scan_complete: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> cnt_ff == n_ff)
      else $error("scan ended before all slots were read");
`endif

endmodule

@@ rtl/core/keyframe_linear_sampler.sv @@
// Keyframe linear sampler: a keyframe table of KEYFRAMES slots with a sampling engine.
// A write transfer stores one keyframe as the back end takes it off the queue. A sample
// transfer scans slots 0 to n-1, with n being frames_in_use capped at KEYFRAMES, one slot
// per cycle through the table's single read port. An exact key is then read and returned,
// and a sample without bracketing keys returns zeros. An interpolation reads both keys,
// forms the differences and products, runs a restoring division, one quotient bit per
// cycle in each of five lanes, adds the quotients to the earlier key's values and then
// reduces the rotation by subtracting shifted full turns.
// A stalled response holds the back end. A two-entry queue in front takes up to two
// more transfers while the back end works or a response waits.
module keyframe_linear_sampler #(
   parameter int KEYFRAMES = kfls_pkg::KEYFRAMES_DEF,
   parameter int FRAC_BITS = kfls_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   kfls_req_if.sink                   req_chan,
   kfls_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_en,
   input  logic [kfls_pkg::CSR_W-1:0] csr_write_data
);
   import kfls_pkg::*;

   logic [CSR_W-1:0] frames_in_use_ff;
   q_head_type       q_head;
   logic             q_pop;

   // frames in use register
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= '0;
      end else if (csr_write_en) begin
         frames_in_use_ff <= csr_write_data;
      end
   end

   kfls_front #(
      .KEYFRAMES (KEYFRAMES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   kfls_back #(
      .KEYFRAMES (KEYFRAMES),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .frames_in_use (frames_in_use_ff),
      .rsp_chan      (rsp_chan)
   );

endmodule

@@ tb/tb_keyframe_linear_sampler.sv @@
// self-checking testbench of the keyframe linear sampler: random traffic, idling and stalls
module tb_keyframe_linear_sampler;
   import kfls_pkg::*;

   localparam int SLOTS = KEYFRAMES_DEF;
   localparam longint TURN = longint'(FULL_TURN) <<< FRAC_BITS_DEF;

   typedef struct {
      op_type          op;
      logic [3:0]      slot;
      logic [15:0]     frame;
      logic [31:0]     vals [LANES];
   } key_req_type;

   typedef struct {
      logic [31:0] vals [LANES];
      match_type   kind;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_W-1:0] csr_write_data = '0;

   kfls_req_if req_chan ();
   kfls_rsp_if rsp_chan ();

   keyframe_linear_sampler DUT (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan.sink),
      .rsp_chan       (rsp_chan.source),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   logic signed [15:0] key_num [SLOTS];
   logic signed [31:0] key_val [SLOTS][LANES];
   int unsigned scan_len = 0;

   // stimulus side copy of the key numbers, for aiming samples near keys
   logic signed [15:0] gen_num [SLOTS];

   key_req_type pending_reqs [$];
   sample_type  expected_samples [$];
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   always #1 clock = ~clock;

   // interpolation between two key values, rounded half away from zero
   function automatic longint blend(longint a, longint b, longint num, longint den);
      longint prod, mag, q;
      prod = (b - a) * num;
      mag = (prod < 0) ? -prod : prod;
      q = (mag + den / 2) / den;
      return a + ((prod < 0) ? -q : q);
   endfunction

   // expected result of one sample transfer
   function automatic sample_type sample_keys(logic signed [15:0] f);
      sample_type r;
      int exact, prv, nxt, n;
      longint num, den, v;
      exact = -1; prv = -1; nxt = -1;
      n = (scan_len > SLOTS) ? SLOTS : scan_len;
      for (int i = 0; i < n; i++) begin
         if (key_num[i] == f) exact = i;
         if (key_num[i] < f && (prv < 0 || key_num[prv] < key_num[i])) prv = i;
         if (key_num[i] > f && (nxt < 0 || key_num[nxt] > key_num[i])) nxt = i;
      end
      if (exact >= 0) begin
         for (int l = 0; l < LANES; l++) r.vals[l] = key_val[exact][l];
         r.kind = MATCH_EXACT;
      end else if (prv >= 0 && nxt >= 0) begin
         num = longint'(f) - longint'(key_num[prv]);
         den = longint'(key_num[nxt]) - longint'(key_num[prv]);
         for (int l = 0; l < LANES; l++) begin
            v = blend(longint'(key_val[prv][l]), longint'(key_val[nxt][l]), num, den);
            if (l == LANE_ROT) begin
               v = v % TURN;
               if (v < 0) v += TURN;
            end
            r.vals[l] = v[31:0];
         end
         r.kind = MATCH_INTERP;
      end else begin
         for (int l = 0; l < LANES; l++) r.vals[l] = '0;
         r.kind = MATCH_NONE;
      end
      return r;
   endfunction

   // driver: one transfer at a time from the pending queue
   always @(posedge clock) begin
      key_req_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            it = pending_reqs.pop_front();
            req_chan.valid        <= 1'b1;
            req_chan.kind         <= it.op;
            req_chan.slot         <= it.slot;
            req_chan.frame_number <= it.frame;
            req_chan.trans_x      <= it.vals[LANE_X];
            req_chan.trans_y      <= it.vals[LANE_Y];
            req_chan.rotation     <= it.vals[LANE_ROT];
            req_chan.scale_x      <= it.vals[LANE_SX];
            req_chan.scale_y      <= it.vals[LANE_SY];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = 1'b0;
      req_chan.slot = '0;
      req_chan.frame_number = '0;
      req_chan.trans_x = '0;
      req_chan.trans_y = '0;
      req_chan.rotation = '0;
      req_chan.scale_x = '0;
      req_chan.scale_y = '0;
      rsp_chan.ready = 1'b0;
   end

   // monitor: predict on request transfers, check response transfers
   always @(posedge clock) begin
      sample_type got, exp_s;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         if (csr_write_en) scan_len = 32'(csr_write_data);
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.kind == OP_WRITE) begin
               key_num[req_chan.slot] = req_chan.frame_number;
               key_val[req_chan.slot][LANE_X]   = req_chan.trans_x;
               key_val[req_chan.slot][LANE_Y]   = req_chan.trans_y;
               key_val[req_chan.slot][LANE_ROT] = req_chan.rotation;
               key_val[req_chan.slot][LANE_SX]  = req_chan.scale_x;
               key_val[req_chan.slot][LANE_SY]  = req_chan.scale_y;
            end else begin
               expected_samples.push_back(sample_keys(req_chan.frame_number));
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.vals[LANE_X]   = rsp_chan.out_x;
            got.vals[LANE_Y]   = rsp_chan.out_y;
            got.vals[LANE_ROT] = rsp_chan.out_rotation;
            got.vals[LANE_SX]  = rsp_chan.out_scale_x;
            got.vals[LANE_SY]  = rsp_chan.out_scale_y;
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response kind %0d", $time, rsp_chan.match_kind);
               errors++;
            end else begin
               exp_s = expected_samples.pop_front();
               for (int l = 0; l < LANES; l++)
                  if (got.vals[l] !== exp_s.vals[l]) begin
                     $display("%0t: lane %0d expected %h actual %h",
                              $time, l, exp_s.vals[l], got.vals[l]);
                     errors++;
                  end
               if (rsp_chan.match_kind !== exp_s.kind) begin
                  $display("%0t: match_kind expected %0d actual %0d",
                           $time, exp_s.kind, rsp_chan.match_kind);
                  errors++;
               end
            end
         end
      end
   end

   task automatic push_write(int slot, int num, logic [31:0] x, logic [31:0] y,
                             logic [31:0] rot, logic [31:0] sx, logic [31:0] sy);
      key_req_type it;
      it.op = OP_WRITE;
      it.slot = 4'(slot);
      it.frame = 16'(num);
      it.vals[LANE_X] = x; it.vals[LANE_Y] = y; it.vals[LANE_ROT] = rot;
      it.vals[LANE_SX] = sx; it.vals[LANE_SY] = sy;
      gen_num[slot] = 16'(num);
      pending_reqs.push_back(it);
   endtask

   task automatic push_sample(int f);
      key_req_type it;
      it.op = OP_SAMPLE;
      it.slot = 4'($urandom);
      it.frame = 16'(f);
      for (int l = 0; l < LANES; l++) it.vals[l] = $urandom;
      pending_reqs.push_back(it);
   endtask

   // wait for an idle block, then write the scan length
   task automatic set_scan_len(int v);
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_chan.valid || expected_samples.size() > 0);
      repeat (200) @(negedge clock);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= CSR_W'(v);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(2 * FULL_TURN) << FRAC_BITS_DEF;
         default: return $urandom;
      endcase
   endfunction

   // random traffic: writes with clustered numbers, samples aimed near keys
   task automatic random_traffic(int count);
      int base, span, f;
      base = $urandom_range(65535) - 32768;
      span = $urandom_range(1) ? 40 : 3000;
      for (int i = 0; i < count; i++) begin
         @(negedge clock);
         if ($urandom_range(99) < 35) begin
            if ($urandom_range(9) == 0) f = $urandom_range(65535) - 32768;
            else f = base + $urandom_range(span);
            push_write($urandom_range(SLOTS - 1), f, rand_val(), rand_val(), rand_val(),
                       rand_val(), rand_val());
         end else begin
            case ($urandom_range(3))
               0: f = $urandom_range(65535) - 32768;
               1: f = int'(gen_num[$urandom_range(SLOTS - 1)]);
               default: f = int'(gen_num[$urandom_range(SLOTS - 1)])
                            + int'($urandom_range(8)) - 4;
            endcase
            push_sample(f);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty scan gives zeros
      push_sample(0);
      // fill every slot before any scan touches it
      push_write(0, -32768, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0);
      for (int s = 1; s < SLOTS - 1; s++)
         push_write(s, s * 100, $urandom, $urandom, (s * 700) << 16, $urandom, $urandom);
      // duplicate key numbers for last-match and lowest-slot ties
      push_write(4, 300, 32'h00010000, 32'h1, 32'h01680000, 32'hffffffff, 32'h2);
      push_write(15, 32767, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                 32'hffffffff);
      set_scan_len(SLOTS);
      push_sample(-32768);
      push_sample(32767);
      push_sample(300);
      push_sample(250);
      push_sample(350);
      push_sample(150);
      push_sample(-100);
      push_sample(20000);
      set_scan_len(31);
      push_sample(-32767);
      push_sample(32766);
      set_scan_len(1);
      push_sample(5);

      // idling and stalling phases with different scan lengths
      set_scan_len(SLOTS);
      idle_pct = 0; stall_pct = 0;
      random_traffic(150);
      set_scan_len($urandom_range(2, SLOTS - 1));
      idle_pct = 75; stall_pct = 0;
      random_traffic(150);
      set_scan_len(SLOTS + $urandom_range(15));
      idle_pct = 0; stall_pct = 75;
      random_traffic(150);
      set_scan_len(SLOTS);
      idle_pct = 9; stall_pct = 9;
      random_traffic(150);

      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_chan.valid || expected_samples.size() > 0);
      repeat (300) @(negedge clock);
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("tb_keyframe_linear_sampler: clean");
      end else begin
         $display("tb_keyframe_linear_sampler: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb_keyframe_linear_sampler: errors");
      $finish;
   end

endmodule
